// ----- sv/sha256_stream_hasher_top_defines.svh -----
// Assertion macros used by the top-level RTL. They compile to nothing in synthesis.
`ifndef SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`define SHA256_STREAM_HASHER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("implication check failed");
`define SHA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SHA_ASSERT_IMPLY(lbl, ante, cons)
`define SHA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- sv/sha_pkg.sv -----
package sha_pkg;

   typedef logic [31:0] word_type;
   typedef logic [7:0][31:0] hash_type;

   // Control from the sequencer to the compression core.
   typedef struct packed {
      logic       load;
      logic [7:0] data;
      logic       compress;
      logic       init_hash;
   } core_ctl_type;

   typedef struct packed {
      logic busy;
   } core_sts_type;

   localparam logic [7:0] PAD_BYTE      = 8'h80;
   localparam logic [5:0] LAST_SLOT     = 6'd63;
   localparam logic [5:0] PRE_LEN_SLOT  = 6'd55;
   localparam logic [5:0] LAST_ROUND    = 6'd63;
   localparam logic [2:0] LAST_WORD_IDX = 3'd7;
   localparam logic [63:0] BYTE_BITS    = 64'd8;

   // Packed so that element 0 is H0.
   localparam hash_type HASH_INIT = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

endpackage

// ----- sv/sha_req_if.sv -----
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_message;

   modport source (output valid, data_byte, byte_valid, end_of_message, input ready);
   modport sink (input valid, data_byte, byte_valid, end_of_message, output ready);
endinterface

// ----- sv/sha_rsp_if.sv -----
interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, digest_word, word_index, last_word, input ready);
   modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/sha256_stream_hasher_top.sv -----
// SHA-256 stream hasher.
// The req channel takes one item per message byte: data_byte with byte_valid
// set, and end_of_message on the last item (it may come without a byte, so an
// empty message is allowed). The rsp channel then delivers eight digest words,
// word_index 0 (most significant) first, last_word set on the eighth.
// The item that completes a 64-byte block starts a compression: the shared
// round unit runs 64 rounds, one per cycle, and folds the result into the hash.
// An ending item adds 9 to 72 padding and length bytes, loaded one per cycle,
// plus one or two compressions, after which the digest words are offered.
// req ready is low while a block compresses, while padding runs and while
// the digest is out. If the receiver stalls, the current digest word holds
// until taken. Synchronous reset loads the initial hash values and clears
// the length and byte position.
module sha256_stream_hasher_top (
   input logic      clock,
   input logic      reset,
   sha_req_if.sink   req_bus,
   sha_rsp_if.source rsp_bus
);
   import sha_pkg::*;
`include "sha256_stream_hasher_top_defines.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_COMP = 2'd1;
   localparam logic [1:0] ST_PAD  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic        first_ff, first_in;
   logic        lenph_ff, lenph_in;
   logic        pend_ff, pend_in;
   logic [2:0]  oidx_ff, oidx_in;

   core_ctl_type ctl;
   core_sts_type sts;
   hash_type     hash;
   logic         req_acc, rsp_acc;
   logic [7:0]   pad_byte;

   sha_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .sts   (sts),
      .hash  (hash)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_acc       = req_bus.valid & req_bus.ready;
   assign rsp_acc       = rsp_bus.valid & rsp_bus.ready;

   // Padding byte: the marker, then zeros, then the length high byte first.
   assign pad_byte = first_ff ? PAD_BYTE : (lenph_ff ? len_ff[63:56] : 8'h00);

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      first_in = first_ff;
      lenph_in = lenph_ff;
      pend_in  = pend_ff;
      oidx_in  = oidx_ff;
      ctl      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req_bus.byte_valid) begin
                  ctl.load = 1'b1;
                  ctl.data = req_bus.data_byte;
                  pos_in   = pos_ff + 6'd1;
                  len_in   = len_ff + BYTE_BITS;
                  if (pos_ff == LAST_SLOT) begin
                     ctl.compress = 1'b1;
                     state_in     = ST_COMP;
                     pend_in      = req_bus.end_of_message;
                     first_in     = req_bus.end_of_message;
                  end else if (req_bus.end_of_message) begin
                     state_in = ST_PAD;
                     first_in = 1'b1;
                  end
               end else if (req_bus.end_of_message) begin
                  state_in = ST_PAD;
                  first_in = 1'b1;
               end
            end
         end
         ST_COMP: begin
            if (!sts.busy) begin
               if (lenph_ff) begin
                  state_in = ST_OUT;
               end else if (pend_ff) begin
                  state_in = ST_PAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_PAD: begin
            ctl.load = 1'b1;
            ctl.data = pad_byte;
            pos_in   = pos_ff + 6'd1;
            first_in = 1'b0;
            if (lenph_ff) begin
               len_in = {len_ff[55:0], 8'h00};
            end
            if (pos_ff == PRE_LEN_SLOT) begin
               lenph_in = 1'b1;
            end
            if (pos_ff == LAST_SLOT) begin
               ctl.compress = 1'b1;
               state_in     = ST_COMP;
               pend_in      = 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_acc) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == LAST_WORD_IDX) begin
                  ctl.init_hash = 1'b1;
                  lenph_in      = 1'b0;
                  pend_in       = 1'b0;
                  len_in        = '0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         len_ff   <= '0;
         first_ff <= 1'b0;
         lenph_ff <= 1'b0;
         pend_ff  <= 1'b0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         first_ff <= first_in;
         lenph_ff <= lenph_in;
         pend_ff  <= pend_in;
         oidx_ff  <= oidx_in;
      end
   end

   // Digest words come straight from the hash registers.
   assign rsp_bus.valid       = (state_ff == ST_OUT);
   assign rsp_bus.digest_word = hash[oidx_ff];
   assign rsp_bus.word_index  = oidx_ff;
   assign rsp_bus.last_word   = (oidx_ff == LAST_WORD_IDX);

   // The sequencer never takes an item or shows a word while rounds run.
   `SHA_ASSERT_IMPLY(a_ready_idle_core, req_bus.ready, !sts.busy)
   `SHA_ASSERT_IMPLY(a_rsp_idle_core, rsp_bus.valid, !sts.busy)
   // The block's last byte always starts a compression.
   `SHA_ASSERT_IMPLY(a_wrap_compress, ctl.load && pos_ff == LAST_SLOT, ctl.compress)
   // After the final word the hash is back at its initial value.
   `SHA_ASSERT_NEXT(a_reload_iv, rsp_acc && rsp_bus.last_word, hash[0] == HASH_INIT[0])

endmodule

// ----- sv/sha_core.sv -----
module sha_core (
   input  logic                 clock,
   input  logic                 reset,
   input  sha_pkg::core_ctl_type ctl,
   output sha_pkg::core_sts_type sts,
   output sha_pkg::hash_type     hash
);
   import sha_pkg::*;

   // Message block and rolling schedule share one 512-bit shift register;
   // the oldest word sits at the top.
   logic [511:0] win_ff, win_in;
   hash_type     wv_ff, wv_in;
   hash_type     hash_ff, hash_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         run_ff, run_in;
   logic         add_ff, add_in;

   word_type w_old, w_1, w_9, w_14, w_sched, w_cur;
   word_type t1, t2, ch, maj;

   // Schedule word for this round.
   always_comb begin
      w_old   = win_ff[511:480];
      w_1     = win_ff[479:448];
      w_9     = win_ff[223:192];
      w_14    = win_ff[63:32];
      w_sched = small_sigma1(w_14) + w_9 + small_sigma0(w_1) + w_old;
      w_cur   = (cnt_ff[5:4] == 2'd0) ? w_old : w_sched;
   end

   // One compression round.
   always_comb begin
      ch  = (wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]);
      maj = (wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]);
      t1  = wv_ff[7] + big_sigma1(wv_ff[4]) + ch + ROUND_K[cnt_ff] + w_cur;
      t2  = big_sigma0(wv_ff[0]) + maj;
   end

   // Next-state selection for the datapath.
   always_comb begin
      win_in  = win_ff;
      wv_in   = wv_ff;
      hash_in = hash_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      add_in  = 1'b0;
      if (ctl.load) begin
         win_in = {win_ff[503:0], ctl.data};
      end else if (run_ff) begin
         win_in = {win_ff[479:0], w_cur};
      end
      if (ctl.load && ctl.compress) begin
         wv_in  = hash_ff;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         wv_in  = {wv_ff[6], wv_ff[5], wv_ff[4], wv_ff[3] + t1,
                   wv_ff[2], wv_ff[1], wv_ff[0], t1 + t2};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == LAST_ROUND) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end
      if (ctl.init_hash) begin
         hash_in = HASH_INIT;
      end else if (add_ff) begin
         for (int i = 0; i < 8; i++) begin
            hash_in[i] = hash_ff[i] + wv_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      wv_ff  <= wv_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         add_ff  <= 1'b0;
         hash_ff <= HASH_INIT;
      end else begin
         run_ff  <= run_in;
         add_ff  <= add_in;
         hash_ff <= hash_in;
      end
   end

   assign sts.busy = run_ff | add_ff;
   assign hash     = hash_ff;

endmodule

// ----- tb/sv/sha256_stream_hasher_top_tb.sv -----
module sha256_stream_hasher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sha_pkg::*;

   typedef struct {
      logic [7:0]  data_byte;
      logic        byte_valid;
      logic        end_of_message;
      logic        check_empty;
   } msg_item_type;

   typedef struct {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_item_type;

   localparam logic [31:0] EMPTY_DIGEST_W0 = 32'he3b0c442;
   localparam logic [31:0] EMPTY_DIGEST_W7 = 32'h7852b855;

   logic clock;
   logic reset;
   sha_req_if req_bus ();
   sha_rsp_if rsp_bus ();

   sha256_stream_hasher_top u_top (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source)
   );

   // Predictor state.
   logic [31:0] msg_words [16];
   logic [5:0]  msg_pos;
   logic [63:0] msg_bits;
   logic [31:0] hash_h [8];

   digest_item_type digest_queue[$];
   msg_item_type    stim[$];
   int              fail_count;
   int              digests_seen;
   int              words_checked;
   int              sink_hold;
   bit              quiet_phase;

   function automatic logic [31:0] rotr(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic run_rounds();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2, s0, s1;
      for (int t = 0; t < 16; t++) w[t] = msg_words[t];
      for (int t = 16; t < 64; t++) begin
         s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
         s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
         w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      for (int i = 0; i < 8; i++) v[i] = hash_h[i];
      for (int t = 0; t < 64; t++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_h[i] += v[i];
   endtask

   task automatic append_byte(logic [7:0] b);
      msg_words[msg_pos[5:2]][(3 - msg_pos[1:0]) * 8 +: 8] = b;
      msg_pos++;
      if (msg_pos == 0) run_rounds();
   endtask

   task automatic reset_hash();
      for (int i = 0; i < 8; i++) hash_h[i] = HASH_INIT[i];
      msg_pos  = '0;
      msg_bits = '0;
   endtask

   // Update the model with one accepted item and queue the digest it yields.
   task automatic predict_digest(msg_item_type it);
      digest_item_type d;
      if (it.byte_valid) begin
         append_byte(it.data_byte);
         msg_bits += BYTE_BITS;
      end
      if (!it.end_of_message) return;
      append_byte(PAD_BYTE);
      while (msg_pos != PRE_LEN_SLOT + 6'd1) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(msg_bits[(7 - i) * 8 +: 8]);
      for (int i = 0; i < 8; i++) begin
         d.digest_word = hash_h[i];
         d.word_index  = 3'(i);
         d.last_word   = (3'(i) == LAST_WORD_IDX);
         // Known digest of the empty message, read straight off the standard.
         if (it.check_empty && i == 0 && d.digest_word != EMPTY_DIGEST_W0) begin
            $error("digest_word: expected %h actual %h", EMPTY_DIGEST_W0, d.digest_word);
            fail_count++;
         end
         if (it.check_empty && i == 7 && d.digest_word != EMPTY_DIGEST_W7) begin
            $error("digest_word: expected %h actual %h", EMPTY_DIGEST_W7, d.digest_word);
            fail_count++;
         end
         digest_queue = {digest_queue, d};
      end
      digests_seen++;
      reset_hash();
   endtask

   function automatic msg_item_type mk(logic [7:0] b, logic bv, logic eom, logic ce = 1'b0);
      msg_item_type it;
      it.data_byte = b; it.byte_valid = bv; it.end_of_message = eom; it.check_empty = ce;
      return it;
   endfunction

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Some tests failed");
      $finish;
   end

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int gap;
      rsp_bus.ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (sink_hold > 0) begin
            rsp_bus.ready <= 0;
            repeat (sink_hold) @(posedge clock);
            sink_hold = 0;
         end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            rsp_bus.ready <= 0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1;
            @(posedge clock);
         end
      end
   end

   // Compare each accepted digest word with the oldest expectation.
   always @(posedge clock) begin
      digest_item_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (digest_queue.size() == 0) begin
            $error("digest_word: unexpected item %h", rsp_bus.digest_word);
            fail_count++;
         end else begin
            e = digest_queue.pop_front();
            words_checked++;
            if (rsp_bus.digest_word !== e.digest_word) begin
               $error("digest_word: expected %h actual %h", e.digest_word, rsp_bus.digest_word);
               fail_count++;
            end
            if (rsp_bus.word_index !== e.word_index) begin
               $error("word_index: expected %0d actual %0d", e.word_index, rsp_bus.word_index);
               fail_count++;
            end
            if (rsp_bus.last_word !== e.last_word) begin
               $error("last_word: expected %0d actual %0d", e.last_word, rsp_bus.last_word);
               fail_count++;
            end
         end
      end
   end

   // Send one item, with an optional idle burst in front of it.
   task automatic send_item(msg_item_type it);
      int gap;
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid          <= 1;
      req_bus.data_byte      <= it.data_byte;
      req_bus.byte_valid     <= it.byte_valid;
      req_bus.end_of_message <= it.end_of_message;
      @(posedge clock iff req_bus.ready);
      predict_digest(it);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 0;
      @(posedge clock);
      while (digest_queue.size() != 0) @(posedge clock);
   endtask

   // Random message: mostly bytes, a few idle items, ends with or without a byte.
   task automatic push_message(int len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 9) == 0) stim = {stim, mk(8'($urandom), 1'b0, 1'b0)};
         stim = {stim, mk(8'($urandom), 1'b1, 1'b0)};
      end
      stim = {stim, mk(8'($urandom), 1'($urandom_range(0, 1)), 1'b1)};
   endtask

   initial begin
      int lens [6];
      lens = '{0, 1, 55, 56, 63, 3};
      fail_count = 0; digests_seen = 0; words_checked = 0;
      sink_hold = 0; quiet_phase = 0;
      reset = 1;
      req_bus.valid = 0; req_bus.data_byte = '0;
      req_bus.byte_valid = 0; req_bus.end_of_message = 0;
      reset_hash();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed table: empty message, idle items, extremes, byte with end.
      stim = '{mk(8'h00, 1'b0, 1'b1, 1'b1),
               mk(8'h5a, 1'b0, 1'b0), mk(8'hff, 1'b0, 1'b1, 1'b1),
               mk(8'h00, 1'b1, 1'b1),
               mk(8'hff, 1'b1, 1'b1),
               mk(8'h61, 1'b1, 1'b0), mk(8'h62, 1'b1, 1'b0), mk(8'h63, 1'b1, 1'b1),
               mk(8'haa, 1'b1, 1'b0), mk(8'h55, 1'b1, 1'b0), mk(8'h00, 1'b0, 1'b1),
               mk(8'h00, 1'b0, 1'b0), mk(8'h80, 1'b1, 1'b0), mk(8'h7f, 1'b1, 1'b1)};
      foreach (stim[i]) send_item(stim[i]);
      wait_drained();

      // Long receiver hold-off while bytes keep coming, so the input stalls.
      stim.delete();
      push_message(20);
      push_message(5);
      sink_hold = 300;
      foreach (stim[i]) send_item(stim[i]);
      wait_drained();

      // Random messages, with padding boundary lengths mixed in.
      stim.delete();
      foreach (lens[i]) push_message(lens[i]);
      while (stim.size() < 200) push_message($urandom_range(0, 12));
      quiet_phase = 0;
      foreach (stim[i]) begin
         if (i > stim.size() - 20) quiet_phase = 1;
         send_item(stim[i]);
      end
      req_bus.valid <= 0;

      fork
         begin
            while (digest_queue.size() != 0) @(posedge clock);
            repeat (200) @(posedge clock);
         end
         begin
            repeat (200000) @(posedge clock);
            $display("Some tests failed");
            $finish;
         end
      join_any
      disable fork;

      $display("Hashed %0d messages and checked %0d digest words, incl. block boundaries.",
               digests_seen, words_checked);
      if (fail_count == 0 && digest_queue.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/sha_pkg.sv
sv/sha_req_if.sv
sv/sha_rsp_if.sv
sv/sha_core.sv
sv/sha256_stream_hasher_top.sv
tb/sv/sha256_stream_hasher_top_tb.sv
